// File: rtl/page_replacement_fifo_lru_defines.svh
// Assertion macros for the checker file of the page replacement block.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_DEFINES_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_DEFINES_SVH

// Checked on every rising edge once reset has been released.
`define PFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PFL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pfl_pkg.sv
package pfl_pkg;

	// Width of a frame number as it is reported on the result stream.
	localparam int unsigned FRAME_IDX_W = 4;
	// Width of the saturating fault counter.
	localparam int unsigned FAULT_W = 16;

	typedef logic [FRAME_IDX_W-1:0] pfl_idx_t;

	// Running search result handed from one frame cell to the next.
	typedef struct packed {
		logic     hit;
		pfl_idx_t hit_idx;
		pfl_idx_t best_idx;
	} pfl_scan_t;

	// Update command broadcast to every frame cell when a reference retires.
	typedef struct packed {
		logic     fill;
		logic     age;
		pfl_idx_t used;
	} pfl_upd_t;

	typedef enum logic {
		PFL_IDLE,
		PFL_SCAN
	} pfl_state_t;

endpackage

// File: rtl/page_replacement_fifo_lru.sv
// Channel | Direction | Handshake          | Contents
// s_      | in        | s_tvalid/s_tready  | s_tdata: page_number
// m_      | out       | m_tvalid/m_tready  | m_tdata: is_hit, frame_index, fault_total
// cfg_    | in        | cfg_valid/cfg_ready| cfg_data: policy_mode
//
// A reference passes from its input transfer through the registered step of
// every frame cell into the result register. Only one reference is in the
// search at a time; the next can be taken in the cycle the result appears.
// Reset (arst_n low) empties every frame, clears the ages, the FIFO pointer,
// the fault count and the policy register, and drops m_tvalid.
// The result register frees the search for the next reference; a result only
// holds the search back when the previous one has not been taken yet.

// Page replacement over a small fully associative set of frames. Each frame
// lives in its own cell, and the cells form a chain: the running search
// result (first hit, and oldest frame so far with its age) moves one cell
// per cycle from frame 0 toward the last frame. Once it leaves the last
// cell the victim is chosen, a single update command is broadcast to all
// cells, and the result is registered for the output stream.
module page_replacement_fifo_lru import pfl_pkg::*; #(
	parameter int unsigned FRAMES    = 4,
	parameter int unsigned PAGE_BITS = 20,
	parameter int unsigned AGE_BITS  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Page references.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// page_number in the low PAGE_BITS bits, zero filled to whole bytes.
	input  logic [((PAGE_BITS+7)/8)*8-1:0]    s_tdata,
	// Results.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// From bit 0 up: is_hit (1), frame_index (4), fault_total (16), zero fill.
	output logic [23:0]                       m_tdata,
	// Policy register: 0 selects FIFO, 1 selects LRU.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data
);

	localparam int unsigned IDX_W = $clog2(FRAMES);
	localparam int unsigned CNT_W = $clog2(FRAMES + 1);
	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

	pfl_state_t state_q, state_d;

	logic [PAGE_BITS-1:0] page_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 mode_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [FAULT_W-1:0]   faults_q;
	logic                 m_tvalid_q;
	logic                 hit_q;
	pfl_idx_t             idx_q;
	logic [FAULT_W-1:0]   total_q;

	logic                 accept;
	logic                 finish;
	pfl_scan_t            res;
	pfl_idx_t             victim;
	logic [FAULT_W-1:0]   faults_d;
	pfl_upd_t             upd;

	pfl_scan_t            chain     [FRAMES+1];
	logic [AGE_BITS-1:0]  age_chain [FRAMES+1];

	// The search starts with no hit and frame 0 at age zero as the oldest.
	assign chain[0]     = '0;
	assign age_chain[0] = '0;

	for (genvar k = 0; k < FRAMES; k++) begin : g_cell
		pfl_cell #(
			.INDEX     (k),
			.PAGE_BITS (PAGE_BITS),
			.AGE_BITS  (AGE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.page      (page_q),
			.upd       (upd),
			.chain_in  (chain[k]),
			.age_in    (age_chain[k]),
			.chain_out (chain[k+1]),
			.age_out   (age_chain[k+1])
		);
	end

	assign res = chain[FRAMES];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PFL_IDLE: begin
				if (s_tvalid) begin
					state_d = PFL_SCAN;
				end
			end
			PFL_SCAN: begin
				if (finish) begin
					state_d = PFL_IDLE;
				end
			end
			default: state_d = PFL_IDLE;
		endcase
	end

	// State outputs. The search result is complete once the counter reaches
	// FRAMES; it waits there while the result register is still full.
	always_comb begin
		s_tready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			PFL_IDLE: begin
				s_tready = 1'b1;
			end
			PFL_SCAN: begin
				finish = (cnt_q == CNT_W'(FRAMES)) && (!m_tvalid_q || m_tready);
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// A hit keeps its frame; a fault takes the FIFO pointer or the oldest frame.
	always_comb begin
		if (res.hit) begin
			victim = res.hit_idx;
		end else if (mode_q) begin
			victim = res.best_idx;
		end else begin
			victim = FRAME_IDX_W'(ptr_q);
		end
	end

	always_comb begin
		faults_d = faults_q;
		if (!res.hit && faults_q != FAULT_MAX) begin
			faults_d = faults_q + 1'b1;
		end
	end

	assign upd.fill = finish && !res.hit;
	assign upd.age  = finish && mode_q;
	assign upd.used = victim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PFL_IDLE;
			cnt_q      <= '0;
			mode_q     <= 1'b0;
			ptr_q      <= '0;
			faults_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == PFL_SCAN && cnt_q != CNT_W'(FRAMES)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				faults_q <= faults_d;
				if (!res.hit && !mode_q) begin
					ptr_q <= (ptr_q == IDX_W'(FRAMES - 1)) ? '0 : ptr_q + 1'b1;
				end
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= s_tdata[PAGE_BITS-1:0];
		end
		if (finish) begin
			hit_q   <= res.hit;
			idx_q   <= victim;
			total_q <= faults_d;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {3'b000, total_q, idx_q, hit_q};

endmodule

// File: rtl/pfl_cell.sv
// One frame of the replacement set: its page, valid bit and age, plus one
// registered step of the hit and oldest-frame search.
module pfl_cell import pfl_pkg::*; #(
	parameter int unsigned INDEX     = 0,
	parameter int unsigned PAGE_BITS = 20,
	parameter int unsigned AGE_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PAGE_BITS-1:0] page,
	input  pfl_upd_t             upd,
	input  pfl_scan_t            chain_in,
	input  logic [AGE_BITS-1:0]  age_in,
	output pfl_scan_t            chain_out,
	output logic [AGE_BITS-1:0]  age_out
);

	localparam pfl_idx_t            MY_IDX  = FRAME_IDX_W'(INDEX);
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [AGE_BITS-1:0]  age_q;
	pfl_scan_t            scan_q;
	logic [AGE_BITS-1:0]  best_age_q;
	pfl_scan_t            scan_d;
	logic [AGE_BITS-1:0]  best_age_d;
	logic                 match;

	assign match = valid_q && (page_q == page);

	always_comb begin
		scan_d     = chain_in;
		best_age_d = age_in;
		if (!chain_in.hit && match) begin
			scan_d.hit     = 1'b1;
			scan_d.hit_idx = MY_IDX;
		end
		// Strictly greater, so an equal age further down keeps the lower index.
		if (age_q > age_in) begin
			scan_d.best_idx = MY_IDX;
			best_age_d      = age_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			best_age_q <= '0;
		end else begin
			scan_q     <= scan_d;
			best_age_q <= best_age_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			if (upd.fill && upd.used == MY_IDX) begin
				valid_q <= 1'b1;
			end
			if (upd.age) begin
				if (upd.used == MY_IDX) begin
					age_q <= '0;
				end else if (age_q != AGE_MAX) begin
					age_q <= age_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.fill && upd.used == MY_IDX) begin
			page_q <= page;
		end
	end

	assign chain_out = scan_q;
	assign age_out   = best_age_q;

endmodule

// File: rtl/pfl_checker.sv
`include "page_replacement_fifo_lru_defines.svh"

// Port-level checks on the page replacement block.
module pfl_checker #(
	parameter int unsigned FRAMES = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	`PFL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`PFL_ASSERT(a_frame_range, m_tvalid |-> m_tdata[4:1] < FRAMES, "frame index out of range")
	`PFL_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second reference taken during search")
	`PFL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result shown during reset")

endmodule

bind page_replacement_fifo_lru pfl_checker #(.FRAMES(FRAMES)) u_pfl_checker (.*);

// File: sim/tb_page_replacement_fifo_lru.sv
// Self-checking bench for the FIFO/LRU page replacement block.

module tb_page_replacement_fifo_lru;
	timeunit 1ns;
	timeprecision 1ps;

	import pfl_pkg::*;

	localparam int unsigned FRAMES    = 4;
	localparam int unsigned PAGE_BITS = 20;
	localparam int unsigned AGE_BITS  = 8;
	localparam int unsigned TDATA_W   = ((PAGE_BITS + 7) / 8) * 8;
	// Wait that lets a reference clear the frame chain.
	localparam int unsigned CHAIN_CYCLES = FRAMES + 1;
	// Length of the long receiver hold-off used to back the block up.
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [AGE_BITS-1:0]  age_t;
	typedef logic [FAULT_W-1:0]   faults_t;

	// Values of the policy register.
	typedef enum logic {
		POLICY_FIFO = 1'b0,
		POLICY_LRU  = 1'b1
	} policy_t;

	// One predicted result of a page reference.
	typedef struct {
		logic     hit;
		pfl_idx_t frame;
		faults_t  faults;
	} outcome_t;

	// Tracks the resident pages, their ages, the FIFO pointer and the fault
	// count, and predicts the outcome of every reference that is taken in.
	class replacement_scoreboard;
		policy_t        policy;
		page_t          pages [FRAMES];
		logic           valid [FRAMES];
		age_t           ages [FRAMES];
		int unsigned    fifo_ptr;
		faults_t        faults;
		outcome_t       outcomes_due [$];
		int unsigned    errors;

		function new();
			policy   = POLICY_FIFO;
			fifo_ptr = 0;
			faults   = '0;
			errors   = 0;
			for (int k = 0; k < FRAMES; k++) begin
				pages[k] = '0;
				valid[k] = 1'b0;
				ages[k]  = '0;
			end
		endfunction

		// Called on every accepted reference; works out its outcome.
		function void note_reference(input page_t page);
			outcome_t o;
			int unsigned best;
			o.hit   = 1'b0;
			o.frame = '0;
			// Only frames that have been filled can match, lowest index first.
			for (int k = 0; k < FRAMES; k++) begin
				if (!o.hit && valid[k] && pages[k] == page) begin
					o.hit   = 1'b1;
					o.frame = pfl_idx_t'(k);
				end
			end
			if (!o.hit) begin
				if (policy == POLICY_FIFO) begin
					o.frame  = pfl_idx_t'(fifo_ptr % FRAMES);
					fifo_ptr = (fifo_ptr % FRAMES + 1) % FRAMES;
				end else begin
					// Oldest frame; a strict compare keeps the lowest index on ties.
					best = 0;
					for (int k = 1; k < FRAMES; k++) begin
						if (ages[k] > ages[best])
							best = k;
					end
					o.frame = pfl_idx_t'(best);
				end
				pages[o.frame] = page;
				valid[o.frame] = 1'b1;
				if (faults != '1)
					faults = faults + 1'b1;
			end
			// Ages only move in LRU mode, and they saturate.
			if (policy == POLICY_LRU) begin
				for (int k = 0; k < FRAMES; k++) begin
					if (k == o.frame)
						ages[k] = '0;
					else if (ages[k] != '1)
						ages[k] = ages[k] + 1'b1;
				end
			end
			o.faults = faults;
			outcomes_due.push_back(o);
		endfunction

		// Called on every accepted result; compares it with the oldest outcome.
		function void check_outcome(input logic [23:0] data);
			outcome_t o;
			logic     got_hit;
			pfl_idx_t got_frame;
			faults_t  got_faults;
			got_hit    = data[0];
			got_frame  = data[FRAME_IDX_W:1];
			got_faults = data[FRAME_IDX_W+FAULT_W:FRAME_IDX_W+1];
			if (outcomes_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, data);
				errors++;
				return;
			end
			o = outcomes_due.pop_front();
			if (got_hit !== o.hit) begin
				$display("%0t: is_hit mismatch, expected %0d, actual %0d",
					$time, o.hit, got_hit);
				errors++;
			end
			if (got_frame !== o.frame) begin
				$display("%0t: frame_index mismatch, expected %0d, actual %0d",
					$time, o.frame, got_frame);
				errors++;
			end
			if (got_faults !== o.faults) begin
				$display("%0t: fault_total mismatch, expected %0d, actual %0d",
					$time, o.faults, got_faults);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return outcomes_due.size();
		endfunction
	endclass

	// Clock, reset and every block input start at a known value. Reset starts
	// released so that asserting it gives the block a real falling edge.
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b1;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [23:0]        m_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data  = 1'b0;

	replacement_scoreboard board = new();

	// Idle rates in percent, changed from phase to phase by the stimulus.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// The stimulus bumps hold_off_requests; the receiver serves each request
	// with one long stretch of m_tready low, counted in its own process.
	int unsigned hold_off_requests = 0;
	int unsigned hold_off_served   = 0;
	int unsigned hold_off_left     = 0;

	// Page pool of the current random segment and the last page sent.
	page_t       pool [8];
	page_t       last_page = '0;

	always #1 clk = ~clk;

	page_replacement_fifo_lru #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS),
		.AGE_BITS (AGE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Result side. A transfer is taken at the edge where m_tvalid and m_tready
	// were both high; the values read right after the edge are the ones the
	// block saw, since every update of the edge is still pending. The next
	// m_tready is then chosen: a long hold-off when one was requested, else a
	// random stall at the current idle rate.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_outcome(m_tdata);
		if (hold_off_left != 0) begin
			m_tready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else if (hold_off_served != hold_off_requests) begin
			hold_off_served = hold_off_served + 1;
			hold_off_left   = HOLD_OFF_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offers one page reference and returns once its transfer has taken place.
	// A random number of idle cycles comes first; with no gap, s_tvalid simply
	// stays high from the previous transfer.
	task automatic send_page(input page_t page);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(page);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_reference(page);
		last_page = page;
	endtask

	// Writes the policy register with the block idle: the input is withdrawn,
	// every outstanding result is collected, and the chain gets its latency
	// once more before the write transfer is offered.
	task automatic write_policy(input policy_t policy);
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (CHAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= policy;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.policy = policy;
		cfg_valid <= 1'b0;
	endtask

	// One random segment under a fixed policy. Most references come from a
	// small pool so that hits, misses and evictions mix; some repeat the last
	// page and some are fully random. With a pool of one or two pages and no
	// random pages, the untouched frames age in LRU mode until they saturate.
	task automatic run_segment(input int unsigned n_items, input policy_t policy,
			input int unsigned pool_size);
		int unsigned r;
		page_t       page;
		write_policy(policy);
		for (int k = 0; k < pool_size; k++) begin
			r = $urandom_range(9);
			if (r == 0)
				pool[k] = '0;
			else if (r == 1)
				pool[k] = '1;
			else
				pool[k] = page_t'($urandom);
		end
		for (int unsigned i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 15)
				page = last_page;
			else if (r < 27 && pool_size > 2)
				page = page_t'($urandom);
			else
				page = pool[$urandom_range(pool_size - 1)];
			send_page(page);
		end
	endtask

	// Random segments with a random policy and pool size.
	task automatic run_phase(input int unsigned n_items);
		int unsigned done;
		int unsigned len;
		done = 0;
		while (done < n_items) begin
			len = $urandom_range(300, 120);
			run_segment(len, policy_t'($urandom_range(1)), $urandom_range(8, 1));
			done += len;
		end
	endtask

	initial begin
		// Reset is asserted and then released on a rising edge.
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First phase: the sender idles rarely, the receiver often.
		send_idle_pct = 10;
		recv_idle_pct = 70;

		// Directed part, starting in the reset policy (FIFO). Page zero must
		// not match any of the empty frames.
		send_page(20'h00000);
		send_page(20'h00000);
		send_page(20'hFFFFF);
		send_page(20'hFFFFF);
		send_page(20'h12345);
		send_page(20'hABCDE);
		// The pointer wraps and evicts frames zero and one.
		send_page(20'h00001);
		send_page(20'h00000);
		send_page(20'h00001);
		// Switching to LRU keeps every frame; all ages start out tied.
		write_policy(POLICY_LRU);
		send_page(20'h12345);
		send_page(20'h55555);
		send_page(20'hAAAAA);
		send_page(20'h00001);
		send_page(20'h55555);
		send_page(20'h7FFFF);
		send_page(20'h80000);
		// Back in FIFO the pointer resumes where it was left.
		write_policy(POLICY_FIFO);
		send_page(20'h80000);
		send_page(20'h0F0F0);
		send_page(20'hF0F0F);

		// The long hold-off: the block is drained first, then the receiver
		// stops while the sender keeps offering, so the result register fills and
		// the next reference waits at the end of the search.
		write_policy(POLICY_LRU);
		hold_off_requests = hold_off_requests + 1;
		run_segment(300, POLICY_LRU, 2);
		run_phase(400);

		// Second phase: the other way round.
		send_idle_pct = 70;
		recv_idle_pct = 10;
		run_segment(300, POLICY_LRU, 1);
		run_phase(400);

		// Third phase: no idling. Random pages in FIFO mode give a run of
		// faults back to back.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_policy(POLICY_FIFO);
		for (int i = 0; i < 30; i++)
			send_page(page_t'($urandom));
		run_segment(100, POLICY_LRU, 6);
		run_segment(100, POLICY_FIFO, 6);

		// Drain: wait for every result, then a few chain lengths more so that
		// any result with nothing expected would still show up.
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4 * CHAIN_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
